[rtl/core/rv32e_pkg.sv]
// Package for the RV32I subset execute step: word types, kind and ALU codes,
// memory size constants. No dependencies.
package rv32e_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [31:0] TOP_WORD  = 32'(MEM_WORDS * 4 - 4);
  localparam logic [4:0]  REG_SP    = 5'd2;
  localparam logic [4:0]  REG_S0    = 5'd8;

  localparam logic [2:0] K_REG  = 3'd0;
  localparam logic [2:0] K_IMM  = 3'd1;
  localparam logic [2:0] K_BR   = 3'd2;
  localparam logic [2:0] K_LW   = 3'd3;
  localparam logic [2:0] K_SW   = 3'd4;
  localparam logic [2:0] K_JAL  = 3'd5;
  localparam logic [2:0] K_JALR = 3'd6;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_XOR  = 4'd2;
  localparam logic [3:0] OP_SLL  = 4'd3;
  localparam logic [3:0] OP_SRL  = 4'd4;
  localparam logic [3:0] OP_SRA  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_AND  = 4'd7;
  localparam logic [3:0] OP_SLT  = 4'd8;
  localparam logic [3:0] OP_SLTU = 4'd9;
  localparam logic [3:0] OP_EQ   = 4'd10;
  localparam logic [3:0] OP_NE   = 4'd11;
  localparam logic [3:0] OP_GE   = 4'd12;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         alu_op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
  } cmd_t;

  typedef struct packed {
    logic        ran;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
  } res_t;

endpackage

[rtl/core/rv32i_subset_execute_step.sv]
// Execute step for an RV32I subset: pc, register file, data memory.
// Depends on rv32e_pkg.
//
//   channel | signals                        | word
//   --------+--------------------------------+---------------------------
//   cmd     | cmd_valid, cmd_ready, cmd      | one decoded instruction
//   res     | res_valid, res_ready, res      | one execution result
//   cfg     | cfg_valid, cfg_ready, cfg_data | exit address
//
// One instruction per cycle while res is not stalled and no clear runs. From
// cmd to res an instruction passes an operand stage (registered register
// file reads) and a result stage (registered data memory read). Results of
// the result stage and the last write back are bypassed into the operand
// stage. After rst the data memory is cleared with cmd_ready low. A stalled
// res holds the result stage and lets the operand stage take one more word.
module rv32i_subset_execute_step
  import rv32e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] exit_address;
  logic [31:0] pc;
  logic        clr_busy;
  logic [MEM_AW-1:0] clr_addr;

  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] dm [MEM_WORDS];
  logic [31:0] dm_q;

  // operand stage
  logic        s1_valid;
  cmd_t        s1;
  logic [31:0] s1_a_q, s1_b_q;
  logic        s1_a_vld, s1_b_vld;
  logic        s1_a_hit, s1_b_hit;
  logic [31:0] fwd_val;

  // result stage
  logic        s2_valid;
  logic        s2_ran;
  logic [31:0] s2_npc;
  logic        s2_wr;
  logic [4:0]  s2_rd;
  logic [31:0] s2_val;
  logic        s2_load;
  logic        s2_ld_ok;
  logic [31:0] s2_wb_val;

  logic cmd_fire, s1_go, s2_go;

  logic [31:0] op_a, op_b, alu_b, alu_y, ea, npc, val;
  logic        halted, wr, is_load, is_store, in_range;
  logic [MEM_AW-1:0] widx;

  function automatic logic [31:0] reset_val(input logic [4:0] idx);
    return (idx == REG_SP || idx == REG_S0) ? TOP_WORD : 32'd0;
  endfunction

  function automatic logic [31:0] alu(input logic [3:0] op, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    unique case (op)
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_XOR:  return a ^ b;
      OP_SLL:  return a << sh;
      OP_SRL:  return a >> sh;
      OP_SRA:  return 32'($signed(a) >>> sh);
      OP_OR:   return a | b;
      OP_AND:  return a & b;
      OP_SLT:  return {31'd0, $signed(a) < $signed(b)};
      OP_SLTU: return {31'd0, a < b};
      OP_EQ:   return {31'd0, a == b};
      OP_NE:   return {31'd0, a != b};
      OP_GE:   return {31'd0, !($signed(a) < $signed(b))};
      default: return 32'd0;
    endcase
  endfunction

  assign s2_go     = s2_valid && res_ready;
  assign s1_go     = s1_valid && (!s2_valid || res_ready);
  assign cmd_ready = !clr_busy && (!s1_valid || s1_go);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cfg_ready = 1'b1;

  assign s2_wb_val = s2_load ? (s2_ld_ok ? dm_q : 32'd0) : s2_val;

  // operand select: result stage, then last write back, then register file
  always_comb begin
    if (s1.src_reg_a == 5'd0) begin
      op_a = 32'd0;
    end else if (s2_valid && s2_wr && s2_rd == s1.src_reg_a) begin
      op_a = s2_wb_val;
    end else if (s1_a_hit) begin
      op_a = fwd_val;
    end else if (s1_a_vld) begin
      op_a = s1_a_q;
    end else begin
      op_a = reset_val(s1.src_reg_a);
    end
    if (s1.src_reg_b == 5'd0) begin
      op_b = 32'd0;
    end else if (s2_valid && s2_wr && s2_rd == s1.src_reg_b) begin
      op_b = s2_wb_val;
    end else if (s1_b_hit) begin
      op_b = fwd_val;
    end else if (s1_b_vld) begin
      op_b = s1_b_q;
    end else begin
      op_b = reset_val(s1.src_reg_b);
    end
  end

  always_comb begin
    halted   = pc == exit_address;
    alu_b    = (s1.kind == K_IMM) ? s1.immediate : op_b;
    alu_y    = alu(s1.alu_op, op_a, alu_b);
    ea       = op_a + s1.immediate;
    in_range = ea[31:2] < 30'(MEM_WORDS);
    widx     = ea[MEM_AW+1:2];
    npc      = pc + 32'd4;
    val      = 32'd0;
    wr       = 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    unique case (s1.kind) inside
      K_REG, K_IMM: begin
        val = alu_y;
        wr  = 1'b1;
      end
      K_BR: begin
        if (alu_y != 32'd0) begin
          npc = pc + s1.immediate;
        end
      end
      K_LW: begin
        is_load = 1'b1;
        wr      = 1'b1;
      end
      K_SW: begin
        is_store = in_range;
      end
      K_JAL: begin
        npc = s1.immediate;
        val = pc + 32'd4;
        wr  = 1'b1;
      end
      K_JALR: begin
        npc = ea;
        val = pc + 32'd4;
        wr  = 1'b1;
      end
      default: begin
      end
    endcase
    if (s1.dest_reg == 5'd0) begin
      wr = 1'b0;
    end
    if (halted) begin
      npc      = pc;
      wr       = 1'b0;
      is_load  = 1'b0;
      is_store = 1'b0;
    end
  end

  // register file: read at accept, write as the result leaves
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_a_q <= rf[cmd.src_reg_a];
      s1_b_q <= rf[cmd.src_reg_b];
    end
    if (s2_go && s2_wr) begin
      rf[s2_rd] <= s2_wb_val;
    end
  end

  // data memory: clear pass after reset, then loads and stores
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      dm[clr_addr] <= 32'd0;
    end else if (s1_go && is_store) begin
      dm[widx] <= op_b;
    end
    if (s1_go && is_load && in_range) begin
      dm_q <= dm[widx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_address <= 32'hFFFF_FFFF;
      pc           <= 32'd0;
      clr_busy     <= 1'b1;
      clr_addr     <= '0;
      rf_valid     <= 32'd0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exit_address <= cfg_data;
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (s2_go && s2_wr) begin
        rf_valid[s2_rd] <= 1'b1;
      end
      if (s1_go) begin
        pc <= npc;
      end
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1       <= cmd;
      s1_a_vld <= rf_valid[cmd.src_reg_a];
      s1_b_vld <= rf_valid[cmd.src_reg_b];
      s1_a_hit <= s2_go && s2_wr && s2_rd == cmd.src_reg_a;
      s1_b_hit <= s2_go && s2_wr && s2_rd == cmd.src_reg_b;
      fwd_val  <= s2_wb_val;
    end
    if (s1_go) begin
      s2_ran   <= !halted;
      s2_npc   <= npc;
      s2_wr    <= wr;
      s2_rd    <= wr ? s1.dest_reg : 5'd0;
      s2_val   <= wr ? val : 32'd0;
      s2_load  <= is_load && wr;
      s2_ld_ok <= in_range;
    end
  end

  assign res_valid         = s2_valid;
  assign res.ran           = s2_ran;
  assign res.next_pc       = s2_npc;
  assign res.reg_written   = s2_wr;
  assign res.written_reg   = s2_rd;
  assign res.written_value = s2_wb_val;

endmodule
